// ===== src/ittw_pkg.sv =====
// Shared types and constants for the idle-timeout timing wheel.
// Used by ittw_ctrl, ittw_dp and the top level; depends on nothing.
package ittw_pkg;

  localparam int SLOTS_DEF    = 30;
  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  localparam int PORT_ID_W = 16;
  localparam int STATUS_W  = 3;
  localparam int FUNC_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_REFRESH = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_SLOT_FULL  = 3'd2,
    ST_EXPIRED    = 3'd3,
    ST_TICK_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SRC_ID,
    SRC_RDATA,
    SRC_ZERO
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_T_CHK,
    S_T_EMIT,
    S_T_RD,
    S_A_DO,
    S_R_CHK,
    S_R_CMP,
    S_R_SH,
    S_R_SHW,
    S_R_OK,
    S_R_NF
  } state_t;

  typedef struct packed {
    logic    ld_item;
    logic    adv_cursor;
    logic    s_prev;
    logic    s_zero;
    logic    s_inc;
    logic    i_inc;
    logic    rd;
    logic    rd_next;
    logic    shift_wr;
    logic    add_wr;
    logic    fill_dec;
    logic    fill_clr;
    logic    emit;
    status_t emit_status;
    src_t    emit_src;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    op_t  func;
    logic fill_zero;
    logic idx_end;
    logic idx_last;
    logic slot_end;
    logic slot_full;
    logic match;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/ittw_ctrl.sv =====
// Sequencer of the timing wheel: decodes each operation and steps the datapath.
// Depends on ittw_pkg.
module ittw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  ittw_pkg::stat_t  stat,
  output logic             in_ready,
  output ittw_pkg::cmd_t   cmd
);

  ittw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ittw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = ittw_pkg::ST_OK;
    cmd.emit_src    = ittw_pkg::SRC_ID;
    in_ready        = 1'b0;
    unique case (state)
      ittw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.ld_item = 1'b1;
          state_next  = ittw_pkg::S_DISPATCH;
        end
      end
      ittw_pkg::S_DISPATCH: begin
        unique case (stat.func)
          ittw_pkg::OP_TICK: begin
            cmd.adv_cursor = 1'b1;
            state_next     = ittw_pkg::S_T_CHK;
          end
          ittw_pkg::OP_ADD: begin
            cmd.s_prev = 1'b1;
            state_next = ittw_pkg::S_A_DO;
          end
          default: begin
            cmd.s_zero = 1'b1;
            state_next = ittw_pkg::S_R_CHK;
          end
        endcase
      end
      ittw_pkg::S_T_CHK: begin
        if (stat.fill_zero) begin
          if (!stat.out_busy) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ittw_pkg::ST_TICK_EMPTY;
            cmd.emit_src    = ittw_pkg::SRC_ZERO;
            cmd.emit_last   = 1'b1;
            state_next      = ittw_pkg::S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = ittw_pkg::S_T_EMIT;
        end
      end
      ittw_pkg::S_T_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ittw_pkg::ST_EXPIRED;
          cmd.emit_src    = ittw_pkg::SRC_RDATA;
          cmd.emit_last   = stat.idx_last;
          cmd.i_inc       = 1'b1;
          if (stat.idx_last) begin
            cmd.fill_clr = 1'b1;
            state_next   = ittw_pkg::S_IDLE;
          end else begin
            state_next = ittw_pkg::S_T_RD;
          end
        end
      end
      ittw_pkg::S_T_RD: begin
        cmd.rd     = 1'b1;
        state_next = ittw_pkg::S_T_EMIT;
      end
      ittw_pkg::S_A_DO: begin
        if (!stat.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (stat.slot_full) begin
            cmd.emit_status = ittw_pkg::ST_SLOT_FULL;
          end else begin
            cmd.add_wr = 1'b1;
          end
          state_next = ittw_pkg::S_IDLE;
        end
      end
      ittw_pkg::S_R_CHK: begin
        if (stat.idx_end) begin
          if (stat.slot_end) begin
            state_next = ittw_pkg::S_R_NF;
          end else begin
            cmd.s_inc = 1'b1;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = ittw_pkg::S_R_CMP;
        end
      end
      ittw_pkg::S_R_CMP: begin
        if (stat.match) begin
          state_next = ittw_pkg::S_R_SH;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = ittw_pkg::S_R_CHK;
        end
      end
      ittw_pkg::S_R_SH: begin
        if (stat.idx_last) begin
          cmd.fill_dec = 1'b1;
          if (stat.func == ittw_pkg::OP_REFRESH) begin
            cmd.s_prev = 1'b1;
            state_next = ittw_pkg::S_A_DO;
          end else begin
            state_next = ittw_pkg::S_R_OK;
          end
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = ittw_pkg::S_R_SHW;
        end
      end
      ittw_pkg::S_R_SHW: begin
        // close the gap: move the next entry down one place
        cmd.shift_wr = 1'b1;
        cmd.i_inc    = 1'b1;
        state_next   = ittw_pkg::S_R_SH;
      end
      ittw_pkg::S_R_OK: begin
        if (!stat.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = ittw_pkg::S_IDLE;
        end
      end
      ittw_pkg::S_R_NF: begin
        if (!stat.out_busy) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ittw_pkg::ST_NOT_FOUND;
          cmd.emit_last   = 1'b1;
          state_next      = ittw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ittw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ittw_dp.sv =====
// Datapath of the timing wheel: cursor, slot fill counts, id memory and output register.
// Depends on ittw_pkg; driven by ittw_ctrl.
module ittw_dp #(
  parameter int SLOTS         = ittw_pkg::SLOTS_DEF,
  parameter int SLOT_CAPACITY = ittw_pkg::CAPACITY_DEF,
  parameter int ID_BITS       = ittw_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ittw_pkg::cmd_t                    cmd,
  output ittw_pkg::stat_t                   stat,
  input  logic [ittw_pkg::FUNC_W-1:0]       in_func,
  input  logic [ittw_pkg::PORT_ID_W-1:0]    in_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ittw_pkg::STATUS_W-1:0]     out_status,
  output logic [ittw_pkg::PORT_ID_W-1:0]    out_id,
  output logic                              out_last
);

  localparam int SW    = $clog2(SLOTS);
  localparam int FW    = $clog2(SLOT_CAPACITY + 1);
  localparam int KW    = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int AW    = SW + KW;
  localparam int DEPTH = SLOTS << KW;

  logic [SW-1:0]      cursor;
  logic [SW-1:0]      slot;
  logic [FW-1:0]      idx;
  logic [FW-1:0]      fill [SLOTS];
  logic [ID_BITS-1:0] mem [DEPTH];
  logic [ID_BITS-1:0] rdata;
  logic [ID_BITS-1:0] id;
  ittw_pkg::op_t      func;

  logic [SW-1:0]      cursor_inc;
  logic [SW-1:0]      cursor_dec;
  logic [FW-1:0]      fill_cur;
  logic [FW-1:0]      idx_inc;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic [31:0]        id_wide;
  logic [31:0]        rdata_wide;
  logic [31:0]        stored_wide;

  assign cursor_inc = (cursor == SW'(SLOTS - 1)) ? '0 : cursor + 1'b1;
  assign cursor_dec = (cursor == '0) ? SW'(SLOTS - 1) : cursor - 1'b1;
  assign fill_cur   = fill[slot];
  assign idx_inc    = idx + 1'b1;

  assign id_wide    = {{(32 - ittw_pkg::PORT_ID_W){1'b0}}, in_id};
  assign rdata_wide = {{(32 - ID_BITS){1'b0}}, rdata};
  assign stored_wide = {{(32 - ID_BITS){1'b0}}, id};

  assign rd_addr = {slot, cmd.rd_next ? idx_inc[KW-1:0] : idx[KW-1:0]};
  assign wr_addr = {slot, cmd.add_wr ? fill_cur[KW-1:0] : idx[KW-1:0]};
  assign wr_data = cmd.add_wr ? id : rdata;

  always_comb begin
    stat.func      = func;
    stat.fill_zero = (fill_cur == '0);
    stat.idx_end   = (idx == fill_cur);
    stat.idx_last  = (idx_inc == fill_cur);
    stat.slot_end  = (slot == SW'(SLOTS - 1));
    stat.slot_full = (fill_cur >= FW'(SLOT_CAPACITY));
    stat.match     = (rdata == id);
    stat.out_busy  = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      func <= ittw_pkg::op_t'(in_func);
      id   <= id_wide[ID_BITS-1:0];
    end
    if (cmd.adv_cursor) begin
      slot <= cursor_inc;
    end else if (cmd.s_prev) begin
      slot <= cursor_dec;
    end else if (cmd.s_zero) begin
      slot <= '0;
    end else if (cmd.s_inc) begin
      slot <= slot + 1'b1;
    end
    if (cmd.adv_cursor || cmd.s_zero || cmd.s_inc) begin
      idx <= '0;
    end else if (cmd.i_inc) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.adv_cursor) begin
      cursor <= cursor_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        fill[s] <= '0;
      end
    end else if (cmd.fill_clr) begin
      fill[slot] <= '0;
    end else if (cmd.fill_dec) begin
      fill[slot] <= fill_cur - 1'b1;
    end else if (cmd.add_wr) begin
      fill[slot] <= fill_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_wr || cmd.add_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd || cmd.rd_next) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_last   <= cmd.emit_last;
      unique case (cmd.emit_src)
        ittw_pkg::SRC_RDATA: out_id <= rdata_wide[ittw_pkg::PORT_ID_W-1:0];
        ittw_pkg::SRC_ZERO:  out_id <= '0;
        default:             out_id <= stored_wide[ittw_pkg::PORT_ID_W-1:0];
      endcase
    end
  end

endmodule

// ===== src/idle_timeout_timing_wheel_unit.sv =====
// Idle-timeout timing wheel: client ids in SLOTS slots, expired on tick.
// Usage: one command word enters on s_axis (tuser = operation, tdata = client id).
// Each command yields one result word on m_axis, a tick one per expired id.
// A result word carries the status in tuser, the id in tdata, tlast on the final one.
// One command at a time; s_axis_tready is high only when idle.
// Tick reports an empty slot with one word, otherwise reads and emits each expired id
// in turn. Refresh and remove scan slot 0 upward, reading each stored entry of each
// slot, then move each entry behind a deleted id down one place; every read goes
// through the single read port of the id memory.
// Reset: cursor returns to slot 0 and all fill counts clear; the id memory is not
// cleared, as only entries below a slot's fill count are ever read.
// Stall: results sit in one output register; while m_axis_tready is low the
// sequencer holds before the next result, and the next command waits for idle.
module idle_timeout_timing_wheel_unit #(
  parameter int SLOTS         = ittw_pkg::SLOTS_DEF,
  parameter int SLOT_CAPACITY = ittw_pkg::CAPACITY_DEF,
  parameter int ID_BITS       = ittw_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] client_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] client_id_out
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  ittw_pkg::cmd_t  cmd;
  ittw_pkg::stat_t stat;
  logic            in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  ittw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  ittw_dp #(
    .SLOTS         (SLOTS),
    .SLOT_CAPACITY (SLOT_CAPACITY),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_axis_tuser),
    .in_id      (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_id     (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

  // a command holds the sequencer busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input accepted again straight after a command");

  // only expiry words can be followed by more words of the same command
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ittw_pkg::ST_EXPIRED) |-> m_axis_tlast)
    else $error("non-expiry result without tlast");

  // an empty tick reports id zero
  a_empty_tick_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ittw_pkg::ST_TICK_EMPTY) |-> (m_axis_tdata == '0))
    else $error("empty tick carries an id");

endmodule

// ===== test/testbench.sv =====
// Testbench for idle_timeout_timing_wheel_unit: drives command words with random gaps,
// predicts each result word with a local copy of the wheel and compares them in order.
// Depends on ittw_pkg and the top level of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ittw_pkg::SLOTS_DEF;
  localparam int CAP   = ittw_pkg::CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    ittw_pkg::status_t status;
    logic [15:0]       id;
    logic              last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  idle_timeout_timing_wheel_unit uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // wheel copy
  int          cur;
  int          fill [NSLOT];
  logic [15:0] ids  [NSLOT][CAP];
  result_t     pending_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          timed_out = 1'b0;
  bit          stall_on = 1'b1;

  function automatic bit take_out(logic [15:0] id);
    for (int s = 0; s < NSLOT; s++)
      for (int i = 0; i < fill[s]; i++)
        if (ids[s][i] == id) begin
          for (int j = i; j + 1 < fill[s]; j++) ids[s][j] = ids[s][j+1];
          fill[s]--;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic bit put_behind(logic [15:0] id);
    int p;
    p = (cur + NSLOT - 1) % NSLOT;
    if (fill[p] >= CAP) return 1'b0;
    ids[p][fill[p]] = id;
    fill[p]++;
    return 1'b1;
  endfunction

  function automatic void predict_wheel(ittw_pkg::op_t op, logic [15:0] id);
    case (op)
      ittw_pkg::OP_TICK: begin
        cur = (cur + 1) % NSLOT;
        if (fill[cur] == 0)
          pending_results.push_back('{ittw_pkg::ST_TICK_EMPTY, 16'd0, 1'b1});
        for (int i = 0; i < fill[cur]; i++)
          pending_results.push_back('{ittw_pkg::ST_EXPIRED, ids[cur][i], i + 1 == fill[cur]});
        fill[cur] = 0;
      end
      ittw_pkg::OP_ADD: pending_results.push_back('{ittw_pkg::status_t'(put_behind(id) ?
        ittw_pkg::ST_OK : ittw_pkg::ST_SLOT_FULL), id, 1'b1});
      ittw_pkg::OP_REFRESH: begin
        if (!take_out(id)) pending_results.push_back('{ittw_pkg::ST_NOT_FOUND, id, 1'b1});
        else pending_results.push_back('{ittw_pkg::status_t'(put_behind(id) ?
          ittw_pkg::ST_OK : ittw_pkg::ST_SLOT_FULL), id, 1'b1});
      end
      default: pending_results.push_back('{ittw_pkg::status_t'(take_out(id) ?
        ittw_pkg::ST_OK : ittw_pkg::ST_NOT_FOUND), id, 1'b1});
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_cmd(ittw_pkg::op_t op, logic [15:0] id);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= id;
    do @(posedge clk); while (!s_axis_tready);
    predict_wheel(op, id);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'($urandom);
  endtask

  // result check
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{ittw_pkg::status_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver stalls: mostly short, now and then a long one
  always @(negedge clk) begin
    if (!stall_on) m_axis_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      stall_left = gap_len();
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) m_axis_tready <= ~m_axis_tready;
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic test_extremes();
    send_cmd(ittw_pkg::OP_TICK, 16'hFFFF);
    send_cmd(ittw_pkg::OP_REMOVE, 16'h0000);
    send_cmd(ittw_pkg::OP_REFRESH, 16'hFFFF);
    send_cmd(ittw_pkg::OP_ADD, 16'h0000);
    send_cmd(ittw_pkg::OP_ADD, 16'hFFFF);
    send_cmd(ittw_pkg::OP_ADD, 16'hFFFF);   // duplicate
    send_cmd(ittw_pkg::OP_REFRESH, 16'hFFFF);
    send_cmd(ittw_pkg::OP_REMOVE, 16'hFFFF);
    send_cmd(ittw_pkg::OP_REMOVE, 16'hFFFF);
    send_cmd(ittw_pkg::OP_REMOVE, 16'hFFFF);
  endtask

  // fill the slot behind the cursor, overflow it, then refresh into it
  task automatic test_full_slot();
    send_cmd(ittw_pkg::OP_ADD, 16'h5AFF);
    send_cmd(ittw_pkg::OP_TICK, 16'h0);
    for (int i = 0; i < CAP + 1; i++) send_cmd(ittw_pkg::OP_ADD, 16'(16'h5A00 + i));
    // held in an older slot, so the re-add meets a full slot and is dropped
    send_cmd(ittw_pkg::OP_REFRESH, 16'h5AFF);
    send_cmd(ittw_pkg::OP_REFRESH, 16'h5A03);
    send_cmd(ittw_pkg::OP_TICK, 16'h0);
    send_cmd(ittw_pkg::OP_ADD, 16'h1234);
  endtask

  task automatic test_random(int n);
    ittw_pkg::op_t op;
    logic [15:0] id;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) stall_on = 1'b0;
      if (k == n / 2 + 40) stall_on = 1'b1;
      op = ittw_pkg::op_t'($urandom_range(0, 9) < 3 ? ittw_pkg::OP_TICK : $urandom_range(1, 3));
      if (op == ittw_pkg::OP_ADD && $urandom_range(0, 2) == 0) op = ittw_pkg::OP_ADD;
      // small id pool for hits, some wide ids for bit coverage
      id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      send_cmd(op, id);
    end
  endtask

  initial begin
    int tail;
    cur = 0;
    foreach (fill[s]) fill[s] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_full_slot();
    for (int t = 0; t < NSLOT; t++) send_cmd(ittw_pkg::OP_TICK, 16'h0);  // wrap the cursor
    test_random(290);
    tail = 0;
    while (pending_results.size() != 0 && tail < 100000) begin
      @(posedge clk);
      tail++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
